// ===== src/solar_to_lunar_date_converter_defines.svh =====
// Assertion macros shared by the date converter RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SOLAR_TO_LUNAR_DATE_CONVERTER_DEFINES_SVH
`define SOLAR_TO_LUNAR_DATE_CONVERTER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define SLDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLDC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sldc_pkg.sv =====
// Types and constants shared by the solar to lunar date converter.
// No dependencies; every other file of the block but the defines header refers to this package.
`timescale 1ns / 1ps

package sldc_pkg;

  // Width of a day number (days counted from the Julian epoch).
  localparam int DN_W = 23;

  // Rows held in the year table and the address width they need.
  localparam int ROM_ROWS = 11;
  localparam int ROM_AW   = $clog2(ROM_ROWS);

  typedef struct packed {
    logic [4:0]  solar_day;
    logic [3:0]  solar_month;
    logic [11:0] solar_year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  lunar_day;
    logic [3:0]  lunar_month;
    logic [11:0] moon_year;
    logic        leap_flag;
    logic        in_range;
    logic [3:0]  stem_index;
    logic [3:0]  branch_index;
  } out_item_t;

  // One row of the year table. The most significant used bit of lengths
  // is month one; a set bit means a 30-day month.
  typedef struct packed {
    logic [4:0]  ny_day;
    logic [3:0]  ny_month;
    logic [3:0]  leap;
    logic [12:0] lengths;
  } year_row_t;

  // Date handed to the day number unit.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } dn_req_t;

endpackage

// ===== src/sldc_if.sv =====
// Valid/ready channels of the date converter, one per direction.
// Depends on sldc_pkg for the item types.
`timescale 1ns / 1ps

interface sldc_in_if;
  logic               valid;
  logic               ready;
  sldc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sldc_out_if;
  logic                valid;
  logic                ready;
  sldc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/solar_to_lunar_date_converter.sv =====
// Channel  | Dir | Fields
// in_i     | in  | solar_day, solar_month, solar_year
// out_o    | out | lunar_day, lunar_month, moon_year, leap_flag, in_range,
//          |     | stem_index, branch_index
//
// A result needs one pass through the two-stage day number unit when the year has no
// table row and two when the date precedes new year and the year before has none; else
// it needs two passes (three before new year), a walk over the lunar months of the row
// and the ST_DIV and ST_DONE states for the stem and branch.
// One item is in work at a time; the next is accepted while a result waits.
// Reset is asynchronous and active low and clears all control state.
//
// Top level of the date converter. Depends on sldc_pkg, sldc_if,
// sldc_daynum and solar_to_lunar_date_converter_defines.svh.
`timescale 1ns / 1ps
`include "solar_to_lunar_date_converter_defines.svh"

module solar_to_lunar_date_converter #(
  parameter int FIRST_TABLE_YEAR = 2020,
  parameter int TABLE_YEARS      = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sldc_in_if.sink           in_i,
  sldc_out_if.source        out_o
);

  localparam int AW       = sldc_pkg::ROM_AW;
  localparam int DiffW    = sldc_pkg::DN_W + 1;
  localparam int RowLimit = (TABLE_YEARS < sldc_pkg::ROM_ROWS) ? TABLE_YEARS
                                                              : sldc_pkg::ROM_ROWS;

  localparam sldc_pkg::year_row_t YearRom [sldc_pkg::ROM_ROWS] = '{
    '{5'd25, 4'd1, 4'd4, 13'h1A95},
    '{5'd12, 4'd2, 4'd0, 13'h0D4A},
    '{5'd1,  4'd2, 4'd0, 13'h0DA5},
    '{5'd22, 4'd1, 4'd2, 13'h15AA},
    '{5'd10, 4'd2, 4'd0, 13'h056A},
    '{5'd29, 4'd1, 4'd0, 13'h0AAD},
    '{5'd17, 4'd2, 4'd6, 13'h1556},
    '{5'd6,  4'd2, 4'd0, 13'h0A5B},
    '{5'd26, 4'd1, 4'd5, 13'h152B},
    '{5'd13, 4'd2, 4'd0, 13'h0A2B},
    '{5'd3,  4'd2, 4'd0, 13'h0953}
  };

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WNOW = 3'd1;
  localparam logic [2:0] ST_WNY  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_PREV = 3'd4;
  localparam logic [2:0] ST_WALK = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  typedef struct packed {
    logic          hit;
    logic [AW-1:0] addr;
  } row_ref_t;

  function automatic row_ref_t row_lookup(input logic [11:0] year);
    logic signed [12:0] off;
    row_ref_t           r;
    off    = $signed({1'b0, year}) - $signed(13'(FIRST_TABLE_YEAR));
    r.hit  = !off[12] && (off[11:0] < 12'(RowLimit));
    r.addr = off[AW-1:0];
    return r;
  endfunction

  logic [2:0]  state_q;
  logic [11:0] sy_q;
  logic [11:0] ry_q;
  logic        row_ok_q;
  logic        prev_q;

  logic [sldc_pkg::DN_W-1:0] jd_now_q;
  logic [sldc_pkg::DN_W-1:0] jd_ny_q;
  logic signed [DiffW-1:0]   diff_q;
  logic [3:0]                walk_i_q;
  logic [3:0]                cur_q;
  logic                      in_leap_q;

  logic [4:0]  res_day_q;
  logic [3:0]  res_month_q;
  logic [11:0] res_ly_q;
  logic        res_leap_q;
  logic        res_ok_q;
  logic [8:0]  q10_q;
  logic [8:0]  q12_q;

  sldc_pkg::out_item_t out_q;
  logic                out_valid_q;

  sldc_pkg::year_row_t rom_q;
  logic                rom_re;
  logic [AW-1:0]       rom_addr;

  row_ref_t cur_look;
  row_ref_t prev_look;
  logic     in_acc;
  logic     go_prev;
  logic     out_load;

  logic                      dn_start;
  sldc_pkg::dn_req_t         dn_req;
  logic                      dn_vld;
  logic [sldc_pkg::DN_W-1:0] dn;

  logic                    leap_row;
  logic [3:0]              walk_total;
  logic [3:0]              bit_idx;
  logic signed [DiffW-1:0] month_len;

  logic [12:0] x10;
  logic [12:0] x12;
  logic [25:0] prod10;
  logic [25:0] prod12;
  logic [12:0] rem10;
  logic [12:0] rem12;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cur_look  = row_lookup(in_i.data.solar_year);
  assign prev_look = row_lookup(sy_q - 12'd1);
  assign go_prev   = (jd_now_q < jd_ny_q) && !prev_q;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Year table reads: the new item's year on accept, the year before when
  // the date turns out to precede that year's new year.
  always_comb begin
    rom_re   = 1'b0;
    rom_addr = cur_look.addr;
    if (state_q == ST_IDLE) begin
      rom_re = in_acc && cur_look.hit;
    end else if (state_q == ST_CMP) begin
      rom_re   = go_prev && prev_look.hit;
      rom_addr = prev_look.addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rom_re) begin
      rom_q <= YearRom[rom_addr];
    end
  end

  always_comb begin
    dn_start = 1'b0;
    dn_req   = '{day: rom_q.ny_day, month: rom_q.ny_month, year: ry_q};
    unique case (state_q)
      ST_IDLE: begin
        dn_start = in_acc;
        dn_req   = '{day:   in_i.data.solar_day,
                     month: in_i.data.solar_month,
                     year:  in_i.data.solar_year};
      end
      ST_WNOW: dn_start = dn_vld && row_ok_q;
      ST_PREV: dn_start = 1'b1;
      default: dn_start = 1'b0;
    endcase
  end

  sldc_daynum u_daynum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dn_start),
    .req_i   (dn_req),
    .valid_o (dn_vld),
    .dn_o    (dn)
  );

  // Month walk: bits are taken from the top of the used part of the map.
  always_comb begin
    leap_row   = (rom_q.leap != 4'd0);
    walk_total = leap_row ? 4'd13 : 4'd12;
    bit_idx    = walk_total - 4'd1 - walk_i_q;
    month_len  = rom_q.lengths[bit_idx] ? DiffW'(30) : DiffW'(29);
  end

  // Stem and branch: quotients by 10 and 12 through reciprocal products.
  always_comb begin
    x10    = 13'(res_ly_q) + 13'd6;
    x12    = 13'(res_ly_q) + 13'd8;
    prod10 = 26'(x10) * 26'd6554;
    prod12 = 26'(x12) * 26'd5462;
    rem10  = x10 - 13'(q10_q) * 13'd10;
    rem12  = x12 - 13'(q12_q) * 13'd12;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      q10_q <= prod10[24:16];
      q12_q <= prod12[24:16];
    end
    if (out_load) begin
      out_q.lunar_day    <= res_day_q;
      out_q.lunar_month  <= res_month_q;
      out_q.moon_year    <= res_ly_q;
      out_q.leap_flag    <= res_leap_q;
      out_q.in_range     <= res_ok_q;
      out_q.stem_index   <= rem10[3:0];
      out_q.branch_index <= rem12[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_ok_q    <= 1'b0;
      prev_q      <= 1'b0;
      sy_q        <= '0;
      ry_q        <= '0;
      jd_now_q    <= '0;
      jd_ny_q     <= '0;
      diff_q      <= '0;
      walk_i_q    <= '0;
      cur_q       <= '0;
      in_leap_q   <= 1'b0;
      res_day_q   <= '0;
      res_month_q <= '0;
      res_ly_q    <= '0;
      res_leap_q  <= 1'b0;
      res_ok_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sy_q     <= in_i.data.solar_year;
            ry_q     <= in_i.data.solar_year;
            row_ok_q <= cur_look.hit;
            prev_q   <= 1'b0;
            state_q  <= ST_WNOW;
          end
        end
        ST_WNOW: begin
          if (dn_vld) begin
            jd_now_q <= dn;
            if (row_ok_q) begin
              state_q <= ST_WNY;
            end else begin
              res_day_q   <= 5'd1;
              res_month_q <= 4'd1;
              res_ly_q    <= sy_q;
              res_leap_q  <= 1'b0;
              res_ok_q    <= 1'b0;
              state_q     <= ST_DIV;
            end
          end
        end
        ST_WNY: begin
          if (dn_vld) begin
            jd_ny_q <= dn;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (go_prev) begin
            prev_q <= 1'b1;
            ry_q   <= sy_q - 12'd1;
            if (prev_look.hit) begin
              state_q <= ST_PREV;
            end else begin
              res_day_q   <= 5'd1;
              res_month_q <= 4'd1;
              res_ly_q    <= sy_q;
              res_leap_q  <= 1'b0;
              res_ok_q    <= 1'b0;
              state_q     <= ST_DIV;
            end
          end else begin
            diff_q    <= $signed({1'b0, jd_now_q}) - $signed({1'b0, jd_ny_q});
            walk_i_q  <= '0;
            cur_q     <= 4'd1;
            in_leap_q <= 1'b0;
            state_q   <= ST_WALK;
          end
        end
        ST_PREV: begin
          state_q <= ST_WNY;
        end
        ST_WALK: begin
          if (walk_i_q == walk_total) begin
            // The date lies past the last month of the lunar year.
            res_day_q   <= 5'd1;
            res_month_q <= 4'd1;
            res_ly_q    <= ry_q;
            res_leap_q  <= 1'b0;
            res_ok_q    <= 1'b1;
            state_q     <= ST_DIV;
          end else if (diff_q < month_len) begin
            res_day_q   <= diff_q[4:0] + 5'd1;
            res_month_q <= cur_q;
            res_ly_q    <= ry_q;
            res_leap_q  <= in_leap_q;
            res_ok_q    <= 1'b1;
            state_q     <= ST_DIV;
          end else begin
            diff_q   <= diff_q - month_len;
            walk_i_q <= walk_i_q + 4'd1;
            // The leap month repeats the number of the month before it.
            if (leap_row && (cur_q == rom_q.leap) && !in_leap_q) begin
              in_leap_q <= 1'b1;
            end else begin
              cur_q     <= cur_q + 4'd1;
              in_leap_q <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SLDC_ASSERT(a_dflt_shape, out_o.valid && !out_o.data.in_range |-> out_o.data.lunar_day == 5'd1 && out_o.data.lunar_month == 4'd1 && !out_o.data.leap_flag, "bad default result")
  `SLDC_ASSERT(a_sb_range, out_o.valid |-> out_o.data.stem_index < 4'd10 && out_o.data.branch_index < 4'd12, "stem or branch out of range")
  `SLDC_ASSERT(a_dn_in_wait, dn_vld |-> state_q == ST_WNOW || state_q == ST_WNY, "day number arrived outside a wait state")
  `SLDC_ASSERT(a_walk_bound, state_q == ST_WALK |-> walk_i_q <= walk_total, "month walk overran the year")
  `SLDC_ASSERT_NXT(a_accept_wait, in_acc, state_q == ST_WNOW && !dn_vld, "accepted item did not start a lookup")

endmodule

// ===== src/sldc_daynum.sv =====
// Two-stage day number unit: Gregorian date in, Julian day number out.
// Depends on sldc_pkg for the request type and the result width.
`timescale 1ns / 1ps

module sldc_daynum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  sldc_pkg::dn_req_t            req_i,
  output logic                         valid_o,
  output logic [sldc_pkg::DN_W-1:0]    dn_o
);

  // floor(30.6001 * k) for the month terms that can occur.
  function automatic logic [8:0] month_term(input logic [4:0] k);
    logic [8:0] t;
    case (k)
      5'd4:    t = 9'd122;
      5'd5:    t = 9'd153;
      5'd6:    t = 9'd183;
      5'd7:    t = 9'd214;
      5'd8:    t = 9'd244;
      5'd9:    t = 9'd275;
      5'd10:   t = 9'd306;
      5'd11:   t = 9'd336;
      5'd12:   t = 9'd367;
      5'd13:   t = 9'd397;
      5'd14:   t = 9'd428;
      5'd15:   t = 9'd459;
      5'd16:   t = 9'd489;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  logic [11:0] y_adj;
  logic [3:0]  m_adj;
  logic [13:0] y_off;
  logic [23:0] prod_e;
  logic [24:0] prod_a;

  logic [21:0] e_q;
  logic [5:0]  a_q;
  logic [8:0]  f_q;
  logic [4:0]  d_q;
  logic        s1_vld_q;

  logic [sldc_pkg::DN_W-1:0] sum;
  logic [sldc_pkg::DN_W-1:0] dn_d, dn_q;
  logic                      vld_q;

  // January and February count as months 13 and 14 of the year before.
  always_comb begin
    if (req_i.month <= 4'd2) begin
      y_adj = req_i.year - 12'd1;
      m_adj = req_i.month + 4'd12;
    end else begin
      y_adj = req_i.year;
      m_adj = req_i.month;
    end
    y_off  = 14'(y_adj) + 14'd4716;
    prod_e = 24'(y_off) * 24'd1461;
    // Century count: 5243 / 2^19 stands in for 1/100 over 12-bit years.
    prod_a = 25'(y_adj) * 25'd5243;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      e_q <= prod_e[23:2];
      a_q <= prod_a[24:19];
      f_q <= month_term(5'(m_adj) + 5'd1);
      d_q <= req_i.day;
    end
  end

  always_comb begin
    sum = sldc_pkg::DN_W'(2) - sldc_pkg::DN_W'(a_q) + sldc_pkg::DN_W'(a_q[5:2])
        + sldc_pkg::DN_W'(d_q) + sldc_pkg::DN_W'(e_q) + sldc_pkg::DN_W'(f_q);
    dn_d = (sum >= sldc_pkg::DN_W'(1525)) ? sum - sldc_pkg::DN_W'(1525)
                                          : sum - sldc_pkg::DN_W'(1524);
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      dn_q <= dn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      vld_q    <= s1_vld_q;
    end
  end

  assign valid_o = vld_q;
  assign dn_o    = dn_q;

endmodule
